/* rtl/core/lppc_pkg.sv */
// Shared types and constants for the lossless pixel predictor codec.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package lppc_pkg;

  localparam int MAX_ROW_LENGTH = 4096;
  localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W          = 17;   // compare width, holds any row length setting
  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int ROW_LEN_CFG_W  = 13;
  localparam int PRED_W         = 4;

  localparam logic [ROW_LEN_CFG_W-1:0] ROW_LENGTH_RST = ROW_LEN_CFG_W'(4096);

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_PREDICTOR  = 2'd1;
  localparam logic [1:0] REG_ROW_LENGTH = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Predictor codes
  localparam logic [PRED_W-1:0] PRED_NONE   = 4'd0;
  localparam logic [PRED_W-1:0] PRED_W_ONLY = 4'd1;
  localparam logic [PRED_W-1:0] PRED_N_ONLY = 4'd2;
  localparam logic [PRED_W-1:0] PRED_NW     = 4'd3;
  localparam logic [PRED_W-1:0] PRED_PLANE  = 4'd4;
  localparam logic [PRED_W-1:0] PRED_N_HWD  = 4'd5;
  localparam logic [PRED_W-1:0] PRED_W_HND  = 4'd6;
  localparam logic [PRED_W-1:0] PRED_AVG    = 4'd7;
  localparam logic [PRED_W-1:0] PRED_MED    = 4'd8;

  // Position of one pixel within the image
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             top;
  } lppc_pos_t;

endpackage

`default_nettype wire

/* rtl/core/lppc_colctl.sv */
// Column and top-row tracker for the pixel stream.
// Depends on lppc_pkg.
`default_nettype none

module lppc_colctl (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire logic                                  sof,
  input  wire logic [lppc_pkg::ROW_LEN_CFG_W-1:0]    row_length,
  output lppc_pkg::lppc_pos_t                        pos
);
  import lppc_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic             top_r, top_nxt;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] col_ext;
  logic [LEN_W-1:0] col_inc;

  // clamp row length to 1..MAX_ROW_LENGTH
  always_comb begin
    len_eff = LEN_W'(row_length);
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_eff > LEN_W'(MAX_ROW_LENGTH)) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end
  end

  // position of the pixel being accepted now
  always_comb begin
    col_ext = LEN_W'(col_r);
    if (sof) begin
      pos.col = '0;
      pos.top = 1'b1;
    end else if (col_ext >= len_eff) begin
      pos.col = '0;           // row shortened mid-row
      pos.top = 1'b0;
    end else begin
      pos.col = col_r;
      pos.top = top_r;
    end
  end

  always_comb begin
    col_inc = LEN_W'(pos.col) + LEN_W'(1);
    if (col_inc >= len_eff) begin
      col_nxt = '0;
      top_nxt = 1'b0;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      top_nxt = pos.top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      top_r <= 1'b1;
    end else if (adv) begin
      col_r <= col_nxt;
      top_r <= top_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lppc_linebuf.sv */
// Previous-row line buffer: one write and one registered read port, with
// same-address forwarding. Depends on lppc_pkg.
`default_nettype none

module lppc_linebuf (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [lppc_pkg::COL_W-1:0]   rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [lppc_pkg::COL_W-1:0]   wr_addr,
  input  wire logic [lppc_pkg::PIX_W-1:0]   wr_data,
  output logic      [lppc_pkg::PIX_W-1:0]   rd_data
);
  import lppc_pkg::*;

  logic [PIX_W-1:0] mem [MAX_ROW_LENGTH];
  logic [PIX_W-1:0] rd_q_r;
  logic [PIX_W-1:0] byp_data_r;
  logic             byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // a write landing on the address being read wins (one-pixel rows)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

`default_nettype wire

/* rtl/core/lppc_predict.sv */
// One-channel predictor with encode/decode arithmetic.
// Depends on lppc_pkg.
`default_nettype none

module lppc_predict (
  input  wire logic                          direction,
  input  wire logic [lppc_pkg::PRED_W-1:0]   pred_sel,
  input  wire logic [lppc_pkg::CHAN_W-1:0]   w,
  input  wire logic [lppc_pkg::CHAN_W-1:0]   n,
  input  wire logic [lppc_pkg::CHAN_W-1:0]   nw,
  input  wire logic [lppc_pkg::CHAN_W-1:0]   v,
  output logic      [lppc_pkg::CHAN_W-1:0]   res,
  output logic      [lppc_pkg::CHAN_W-1:0]   pix
);
  import lppc_pkg::*;

  logic signed [9:0] ws, ns, nws;
  logic signed [9:0] d_wnw, d_nnw;
  logic signed [9:0] h_wnw, h_nnw;   // halves, truncated toward zero
  logic signed [9:0] plane;
  logic [CHAN_W-1:0] mx, mn;
  logic signed [9:0] pred;

  always_comb begin
    ws    = 10'(signed'({2'b00, w}));
    ns    = 10'(signed'({2'b00, n}));
    nws   = 10'(signed'({2'b00, nw}));
    d_wnw = ws - nws;
    d_nnw = ns - nws;
    h_wnw = (d_wnw + 10'(signed'({9'b0, d_wnw[9]}))) >>> 1;
    h_nnw = (d_nnw + 10'(signed'({9'b0, d_nnw[9]}))) >>> 1;
    plane = ns + ws - nws;
    mx    = (w > n) ? w : n;
    mn    = (w > n) ? n : w;
  end

  always_comb begin
    unique case (pred_sel)
      PRED_W_ONLY: pred = ws;
      PRED_N_ONLY: pred = ns;
      PRED_NW:     pred = nws;
      PRED_PLANE:  pred = plane;
      PRED_N_HWD:  pred = ns + h_wnw;
      PRED_W_HND:  pred = ws + h_nnw;
      PRED_AVG:    pred = (ns + ws) >>> 1;
      PRED_MED: begin
        if (nw >= mx) begin
          pred = 10'(signed'({2'b00, mn}));
        end else if (nw <= mn) begin
          pred = 10'(signed'({2'b00, mx}));
        end else begin
          pred = plane;
        end
      end
      default:     pred = '0;   // none, and unused codes
    endcase
  end

  // everything is mod 256, so only the low byte of the prediction matters
  always_comb begin
    if (direction == DIR_DECODE) begin
      res = v + pred[CHAN_W-1:0];
      pix = res;
    end else begin
      res = v - pred[CHAN_W-1:0];
      pix = v;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lossless_pixel_predictor_codec.sv */
// Top level of the lossless pixel predictor codec: config registers,
// pipeline control. Depends on lppc_pkg, lppc_colctl, lppc_linebuf, lppc_predict.
`default_nettype none

// Lossless-JPEG style predictor (W, N, NW, planar and half forms, median
// edge detector) run per channel over a 3-channel pixel stream in raster
// order. Encode turns pixels into residuals mod 256; decode turns residuals
// back into pixels and feeds the decoded pixels forward as neighbours.
// Throughput is one pixel per clock while out_tready does not hold the
// output register. Stage 0 tracks the column and reads the previous-row
// pixel from the single line-buffer memory (one read, one write port);
// stage 1 runs the prediction and the add/subtract into the output
// register, with the west pixel fed straight back for the next pixel.
// Pixels outside the image count as 0. tuser marks start of image;
// without it pixels continue the current image. Config (direction,
// predictor_select, row_length at 0x0, 0x4, 0x8) should be written while
// the stream is idle; it applies from the next pixel. The line buffer needs
// no clearing after reset.
module lossless_pixel_predictor_codec (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // pixel/residual input; tdata: [7:0] chan_blue, [15:8] chan_green,
  // [23:16] chan_red
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tuser,   // [0] start_of_image

  // result; tdata: [7:0] out_blue, [15:8] out_green, [23:16] out_red
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,

  // configuration (APB style)
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import lppc_pkg::*;

  // ---------------- configuration registers ----------------
  logic                     direction_r;
  logic [PRED_W-1:0]        pred_sel_r;
  logic [ROW_LEN_CFG_W-1:0] row_length_r;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIR_ENCODE;
      pred_sel_r   <= PRED_NONE;
      row_length_r <= ROW_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_DIRECTION:  direction_r  <= cfg_pwdata[0];
        REG_PREDICTOR:  pred_sel_r   <= cfg_pwdata[PRED_W-1:0];
        REG_ROW_LENGTH: row_length_r <= cfg_pwdata[ROW_LEN_CFG_W-1:0];
        default: ;      // unmapped, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_DIRECTION:  cfg_prdata = 32'(direction_r);
      REG_PREDICTOR:  cfg_prdata = 32'(pred_sel_r);
      REG_ROW_LENGTH: cfg_prdata = 32'(row_length_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic in_fire, s1_fire, out_free;
  logic s1_valid_r;
  logic out_valid_r;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- stage 0: position + line-buffer read ----------------
  lppc_pos_t pos;

  lppc_colctl u_colctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (in_fire),
    .sof        (in_tuser),
    .row_length (row_length_r),
    .pos        (pos)
  );

  lppc_pos_t        s1_pos_r;
  logic [PIX_W-1:0] s1_chan_r;
  logic [PIX_W-1:0] row_above;
  logic [PIX_W-1:0] s1_pix;

  lppc_linebuf u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (pos.col),
    .wr_en   (s1_fire),
    .wr_addr (s1_pos_r.col),
    .wr_data (s1_pix),
    .rd_data (row_above)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r  <= pos;
      s1_chan_r <= in_tdata;
    end
  end

  // ---------------- stage 1: predict ----------------
  logic [PIX_W-1:0] west_r, nw_r;
  logic [PIX_W-1:0] n_pix, w_pix, nw_pix;
  logic [PIX_W-1:0] s1_res;

  // first column of a row has no west/northwest; top row has no north
  assign n_pix  = s1_pos_r.top ? '0 : row_above;
  assign w_pix  = (s1_pos_r.col == '0) ? '0 : west_r;
  assign nw_pix = (s1_pos_r.col == '0) ? '0 : nw_r;

  for (genvar k = 0; k < 3; k++) begin : g_chan
    lppc_predict u_predict (
      .direction (direction_r),
      .pred_sel  (pred_sel_r),
      .w         (w_pix[k*CHAN_W +: CHAN_W]),
      .n         (n_pix[k*CHAN_W +: CHAN_W]),
      .nw        (nw_pix[k*CHAN_W +: CHAN_W]),
      .v         (s1_chan_r[k*CHAN_W +: CHAN_W]),
      .res       (s1_res[k*CHAN_W +: CHAN_W]),
      .pix       (s1_pix[k*CHAN_W +: CHAN_W])
    );
  end

  // neighbours for the next pixel
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      west_r <= s1_pix;
      nw_r   <= n_pix;
    end
  end

  // ---------------- output register ----------------
  logic [PIX_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= s1_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* tb/tb_lossless_pixel_predictor_codec.sv */
// Self-checking testbench for lossless_pixel_predictor_codec: streams pixels and
// residuals through the block and checks every result against a local predictor.
// Depends on lppc_pkg and the RTL under rtl/core.

module tb_lossless_pixel_predictor_codec;
  import lppc_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;      // margin after the last result has come back

  // codes 9..15 are unused predictor codes, treated as no prediction
  localparam logic [PRED_W-1:0] PRED_UNUSED_MIN = 4'd9;
  localparam logic [PRED_W-1:0] PRED_UNUSED_MAX = 4'd15;

  // how the first pixel of a phase is marked
  localparam int SOF_AUTO  = 0;   // random, unless continuing would read stale rows
  localparam int SOF_FORCE = 1;
  localparam int SOF_NONE  = 2;   // continue the current image if safe

  typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_EXTREME} pixel_style_t;

  // Predicts the codec output for each accepted pixel and holds the results
  // still owed by the block, oldest first.
  class pixel_scoreboard;
    logic                     dir;
    logic [PRED_W-1:0]        pred_sel;
    logic [ROW_LEN_CFG_W-1:0] row_len;
    logic [PIX_W-1:0]         row_store [MAX_ROW_LENGTH];
    bit                       written   [MAX_ROW_LENGTH];
    logic [PIX_W-1:0]         west;
    logic [PIX_W-1:0]         northwest;
    int unsigned              col;
    bit                       top;
    logic [PIX_W-1:0]         expected_q [$];
    string                    field_name [3];
    int                       errors;
    int                       checked;

    function new();
      dir        = DIR_ENCODE;
      pred_sel   = PRED_NONE;
      row_len    = ROW_LENGTH_RST;
      west       = '0;
      northwest  = '0;
      col        = 0;
      top        = 1'b1;
      errors     = 0;
      checked    = 0;
      field_name = '{"out_blue", "out_green", "out_red"};
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      unique case (idx)
        REG_DIRECTION:  dir      = value[0];
        REG_PREDICTOR:  pred_sel = value[PRED_W-1:0];
        REG_ROW_LENGTH: row_len  = value[ROW_LEN_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len(logic [ROW_LEN_CFG_W-1:0] len);
      if (len == 0) return 1;
      if (len > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
      return len;
    endfunction

    // True when continuing the current image at row length len only reads
    // line-buffer entries that have been written since reset.
    function bit continue_ok(logic [ROW_LEN_CFG_W-1:0] len);
      int unsigned lim;
      lim = eff_len(len);
      if (top || col >= lim) return 1'b1;
      for (int unsigned c = col; c < lim; c++)
        if (!written[c]) return 1'b0;
      return 1'b1;
    endfunction

    function int predict_chan(int w, int n, int nw);
      int mx, mn;
      mx = (w > n) ? w : n;
      mn = (w < n) ? w : n;
      unique case (pred_sel)
        PRED_W_ONLY: return w;
        PRED_N_ONLY: return n;
        PRED_NW:     return nw;
        PRED_PLANE:  return n + w - nw;
        PRED_N_HWD:  return n + (w - nw) / 2;
        PRED_W_HND:  return w + (n - nw) / 2;
        PRED_AVG:    return (n + w) / 2;
        PRED_MED: begin
          if (nw >= mx) return mn;
          if (nw <= mn) return mx;
          return w + n - nw;
        end
        default:     return 0;
      endcase
    endfunction

    function void restart_row();
      col       = 0;
      west      = '0;
      northwest = '0;
    endfunction

    function void note_pixel(logic sof, logic [PIX_W-1:0] pix);
      int unsigned      lim;
      logic [PIX_W-1:0] above, stored, res;
      int               v, p;
      lim = eff_len(row_len);
      if (sof) begin
        restart_row();
        top = 1'b1;
      end else if (col >= lim) begin
        // row length dropped below the current column: row ends here
        restart_row();
        top = 1'b0;
      end
      above = top ? '0 : row_store[col];
      for (int k = 0; k < 3; k++) begin
        v = pix[8*k +: 8];
        p = predict_chan(west[8*k +: 8], above[8*k +: 8], northwest[8*k +: 8]);
        if (dir == DIR_DECODE) begin
          res[8*k +: 8]    = 8'(v + p);
          stored[8*k +: 8] = res[8*k +: 8];
        end else begin
          res[8*k +: 8]    = 8'(v - p);
          stored[8*k +: 8] = pix[8*k +: 8];
        end
      end
      northwest      = above;
      west           = stored;
      row_store[col] = stored;
      written[col]   = 1'b1;
      col++;
      if (col >= lim) begin
        restart_row();
        top = 1'b0;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [PIX_W-1:0] actual);
      logic [PIX_W-1:0] exp_pix;
      if (expected_q.size() == 0) begin
        $error("result with no pixel outstanding: out_tdata=%h", actual);
        errors++;
        return;
      end
      exp_pix = expected_q.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (actual[8*k +: 8] !== exp_pix[8*k +: 8]) begin
          $error("%s mismatch: expected %0d, actual %0d", field_name[k],
                 exp_pix[8*k +: 8], actual[8*k +: 8]);
          errors++;
        end
      end
      checked++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pixel_scoreboard sb;
  int              items_sent    = 0;
  int              phase_count   = 0;
  int              cycle_count   = 0;
  int              send_idle_pct = 35;
  int              recv_idle_pct = 67;
  logic [PIX_W-1:0] last_pix     = '0;

  lossless_pixel_predictor_codec dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random backpressure, sampled on the rising edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Leaves psel high so back-to-back writes never lower and raise it in
  // one step; the caller closes the bus.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic dir, input logic [PRED_W-1:0] pred,
                              input logic [ROW_LEN_CFG_W-1:0] len);
    apb_write(REG_DIRECTION, 32'(dir));
    apb_write(REG_PREDICTOR, 32'(pred));
    apb_write(REG_ROW_LENGTH, 32'(len));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One input transaction; entered and left at a falling edge. Valid only
  // drops when an idle gap is actually inserted.
  task automatic send_pixel(input logic sof, input logic [PIX_W-1:0] pix);
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 35;
      recv_idle_pct = 67;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= sof;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(sof, pix);
    items_sent++;
    @(negedge clk);
  endtask

  // Block is idle once every expected result has come back.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] next_chan(pixel_style_t style, logic [7:0] prev);
    unique case (style)
      STYLE_SMOOTH:  return 8'(int'(prev) + int'($urandom_range(0, 8)) - 4);
      STYLE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:       return 8'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic dir, input logic [PRED_W-1:0] pred,
                           input logic [ROW_LEN_CFG_W-1:0] len, input int n_items,
                           input int sof_mode, input pixel_style_t style);
    logic             first_sof, sof;
    logic [PIX_W-1:0] pix;
    drain_pipeline();
    program_regs(dir, pred, len);
    // never continue into line-buffer entries that were never written
    first_sof = (sof_mode == SOF_FORCE) || !sb.continue_ok(len) ||
                (sof_mode == SOF_AUTO && $urandom_range(0, 1) == 1);
    for (int i = 0; i < n_items; i++) begin
      sof = (i == 0) ? first_sof : ($urandom_range(0, 99) < 2);
      for (int k = 0; k < 3; k++) pix[8*k +: 8] = next_chan(style, last_pix[8*k +: 8]);
      send_pixel(sof, pix);
      last_pix = pix;
    end
    phase_count++;
  endtask

  // mostly short rows so most pixels see a real north neighbour
  function automatic logic [ROW_LEN_CFG_W-1:0] pick_row_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return ROW_LEN_CFG_W'(1);
    if (r < 70) return ROW_LEN_CFG_W'($urandom_range(2, 12));
    if (r < 88) return ROW_LEN_CFG_W'($urandom_range(13, 80));
    if (r < 94) return ROW_LEN_CFG_W'($urandom_range(MAX_ROW_LENGTH, 8191));
    return ROW_LEN_CFG_W'($urandom_range(81, 300));
  endfunction

  function automatic int items_for(logic [ROW_LEN_CFG_W-1:0] len);
    int unsigned lim;
    int          n;
    lim = sb.eff_len(len);
    if (lim > 300) return int'($urandom_range(5, 30));
    n = int'(lim * $urandom_range(2, 4));
    if (n < 8) n = 8;
    if (n > 120) n = 120;
    return n;
  endfunction

  initial begin
    int                       p;
    logic                     dir;
    logic [PRED_W-1:0]        pred;
    logic [ROW_LEN_CFG_W-1:0] len;
    int                       r;
    pixel_style_t             style;

    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: median predictor on 0/255 over three rows
    run_phase(DIR_ENCODE, PRED_MED, 13'd3, 9, SOF_FORCE, STYLE_EXTREME);
    // unused predictor code, zero row length, image continues unmarked
    run_phase(DIR_DECODE, PRED_UNUSED_MAX, 13'd0, 3, SOF_NONE, STYLE_EXTREME);
    // row length above the maximum
    run_phase(DIR_ENCODE, PRED_PLANE, 13'h1FFF, 6, SOF_FORCE, STYLE_NOISE);
    // row length lowered mid-row: row ends before the next pixel
    run_phase(DIR_DECODE, PRED_N_HWD, 13'd2, 4, SOF_NONE, STYLE_NOISE);

    // random phases; the first 32 sweep every predictor code in both directions
    p = 0;
    while (items_sent < ITEM_TARGET) begin
      if (p < 32) begin
        pred = PRED_W'(p % 16);
        dir  = (p >= 16) ? DIR_DECODE : DIR_ENCODE;
      end else begin
        dir  = ($urandom_range(0, 1) != 0) ? DIR_DECODE : DIR_ENCODE;
        pred = ($urandom_range(0, 9) == 0) ?
               PRED_W'($urandom_range(PRED_UNUSED_MIN, PRED_UNUSED_MAX)) :
               PRED_W'($urandom_range(PRED_NONE, PRED_MED));
      end
      len = pick_row_length();
      r   = $urandom_range(0, 9);
      style = (r < 6) ? STYLE_NOISE : (r < 9) ? STYLE_SMOOTH : STYLE_EXTREME;
      run_phase(dir, pred, len, items_for(len), SOF_AUTO, style);
      p++;
    end

    drain_pipeline();
    $display("Covered %0d results over %0d register phases: all predictor codes,",
             sb.checked, phase_count);
    $display("encode and decode, row lengths 0 to 8191, marked and unmarked images.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lppc_pkg.sv
rtl/core/lppc_colctl.sv
rtl/core/lppc_linebuf.sv
rtl/core/lppc_predict.sv
rtl/core/lossless_pixel_predictor_codec.sv
tb/tb_lossless_pixel_predictor_codec.sv
